>>> sv/mmc_pkg.sv
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared constants, types and elaboration-time functions of the model
// matrix composer.
// ----------------------------------------------------------------------------
package mmc_pkg;

  // Default configuration
  localparam int SineTableDepth = 1024;
  localparam int FractionBits   = 16;

  // Angle units: 1/64 degree
  localparam int QuarterUnits = 5760;
  localparam int TurnUnits    = 23040;

  // Pipeline depths of the sine/cosine unit and the matrix unit
  localparam int SincosLatency = 8;
  localparam int MatrixLatency = 6;

  // Sine series constants, Q30
  localparam longint HalfPiQ30   = 64'sd1686629713;
  localparam int     SeriesTerms = 12;

  // Q16.16 value of 1.0 for the bottom row of the translation column
  localparam logic [31:0] OneQ16 = 32'h0001_0000;

  // Finished matrix: col[j][i] is row i of column j, rows 0..2
  typedef struct packed {
    logic [3:0][2:0][31:0] col;
  } mat_t;

  // Signed division truncating toward zero, by shift and subtract
  function automatic longint div_trunc(input longint num, input longint den);
    logic [63:0] un;
    logic [63:0] ud;
    logic [63:0] qt;
    logic [63:0] rm;
    logic        neg;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? 64'(-num) : 64'(num);
    ud  = (den < 0) ? 64'(-den) : 64'(den);
    qt  = '0;
    rm  = '0;
    for (int b = 63; b >= 0; b--) begin
      rm = {rm[62:0], un[b]};
      if (rm >= ud) begin
        rm    = rm - ud;
        qt[b] = 1'b1;
      end
    end
    return neg ? -longint'(qt) : longint'(qt);
  endfunction

  // Quarter-wave sine entry k, rounded to frac fraction bits, clamped to [0, 1.0]
  function automatic longint sine_entry(input longint k, input int depth, input int frac);
    longint x;
    longint term;
    longint sum;
    longint e;
    longint dv;
    x    = div_trunc(k * HalfPiQ30, longint'(depth));
    term = x;
    sum  = x;
    for (int n = 1; n <= SeriesTerms; n++) begin
      term = (term * x + (64'sd1 <<< 29)) >>> 30;
      term = (term * x + (64'sd1 <<< 29)) >>> 30;
      dv   = longint'((2 * n) * (2 * n + 1));
      term = div_trunc(-term, dv);
      sum  = sum + term;
    end
    e = (sum + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
    if (e < 0) begin
      e = 0;
    end
    if (e > (64'sd1 <<< frac)) begin
      e = 64'sd1 <<< frac;
    end
    return e;
  endfunction

  // Clamp to the signed 32 bit range
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> sv/mmc_if.sv
// ----------------------------------------------------------------------------
// mmc_in_if / mmc_out_if
// Valid/ready channels of the model matrix composer: entity in, column out.
// ----------------------------------------------------------------------------
interface mmc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] scale_x;
  logic signed [15:0] scale_y;
  logic signed [15:0] scale_z;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z,
                  pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z,
                  pos_x, pos_y, pos_z, output ready);
endinterface

interface mmc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         column_index;
  logic signed [31:0] elem_row0;
  logic signed [31:0] elem_row1;
  logic signed [31:0] elem_row2;
  logic signed [31:0] elem_row3;
  logic               last_column;

  modport source (output valid, column_index, elem_row0, elem_row1, elem_row2, elem_row3,
                  last_column, input ready);
  modport sink   (input valid, column_index, elem_row0, elem_row1, elem_row2, elem_row3,
                  last_column, output ready);
endinterface

>>> sv/mmc_sincos.sv
// ----------------------------------------------------------------------------
// mmc_sincos
// Pipelined sine (or cosine) of an angle in 1/64 degree via a quarter-wave
// table. Eight register stages, one angle per cycle while enabled.
// ----------------------------------------------------------------------------
module mmc_sincos #(
  parameter int D   = mmc_pkg::SineTableDepth,
  parameter int F   = mmc_pkg::FractionBits,
  parameter bit COS = 1'b0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [15:0]  angle_i,
  output logic signed [F+1:0] value_o
);

  localparam int QU = mmc_pkg::QuarterUnits;
  localparam int TU = mmc_pkg::TurnUnits;
  localparam int QH = QU / 2;
  localparam int NW = $clog2(QU * D + QH + 1);
  localparam longint unsigned RECIP = (64'd1 << 32) / QU;
  localparam int RW = $clog2(RECIP + 1);
  localparam int PW = NW + RW;
  localparam int IW = $clog2(D + 1);

  // Quarter-wave table, built at elaboration
  logic [F:0] tab [D+1];
  for (genvar k = 0; k <= D; k++) begin : g_tab
    localparam longint Entry = mmc_pkg::sine_entry(longint'(k), D, F);
    assign tab[k] = Entry[F:0];
  end

  logic signed [17:0] a_ext;
  logic [16:0]        a_pos;
  logic [14:0]        m_d, m_q;
  logic [1:0]         q_d, q2_q, q3_q, q4_q, q5_q;
  logic [12:0]        r_d, r_q;
  logic [NW-1:0]      num_q, num4_q;
  logic [PW-1:0]      prod_q;
  logic [IW-1:0]      q0;
  logic [NW:0]        rem;
  logic [IW-1:0]      idx5_q, idx6_q;
  logic               neg6_q, neg7_q;
  logic [F:0]         sin7_q;
  logic signed [F+1:0] val_q;

  // Reduce to one turn: offset positive, then subtract at most three turns
  always_comb begin
    a_ext = 18'(angle_i) + (COS ? 18'sd5760 : 18'sd0) + 18'sd46080;
    a_pos = a_ext[16:0];
    priority if (a_pos >= 17'(3 * TU)) begin
      m_d = 15'(a_pos - 17'(3 * TU));
    end else if (a_pos >= 17'(2 * TU)) begin
      m_d = 15'(a_pos - 17'(2 * TU));
    end else if (a_pos >= 17'(TU)) begin
      m_d = 15'(a_pos - 17'(TU));
    end else begin
      m_d = a_pos[14:0];
    end
  end

  // Split into quadrant and remainder
  always_comb begin
    priority if (m_q >= 15'(3 * QU)) begin
      q_d = 2'd3;
      r_d = 13'(m_q - 15'(3 * QU));
    end else if (m_q >= 15'(2 * QU)) begin
      q_d = 2'd2;
      r_d = 13'(m_q - 15'(2 * QU));
    end else if (m_q >= 15'(QU)) begin
      q_d = 2'd1;
      r_d = 13'(m_q - 15'(QU));
    end else begin
      q_d = 2'd0;
      r_d = m_q[12:0];
    end
  end

  // Reciprocal quotient is low by at most one: correct it
  always_comb begin
    q0  = IW'(prod_q >> 32);
    rem = (NW + 1)'(num4_q) - (NW + 1)'((NW + 1)'(q0) * (NW + 1)'(QU));
  end

  // Advance all stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= m_d;
      q2_q   <= q_d;
      r_q    <= r_d;
      q3_q   <= q2_q;
      num_q  <= NW'(32'(r_q) * 32'(D) + 32'(QH));
      q4_q   <= q3_q;
      prod_q <= PW'(num_q) * PW'(RECIP);
      num4_q <= num_q;
      q5_q   <= q4_q;
      idx5_q <= (rem >= (NW + 1)'(QU)) ? IW'(q0 + IW'(1)) : q0;
      idx6_q <= q5_q[0] ? IW'(IW'(D) - idx5_q) : idx5_q;
      neg6_q <= q5_q[1];
      sin7_q <= tab[idx6_q];
      neg7_q <= neg6_q;
      val_q  <= neg7_q ? -$signed({1'b0, sin7_q}) : $signed({1'b0, sin7_q});
    end
  end

  assign value_o = val_q;

endmodule

>>> sv/mmc_matrix.sv
// ----------------------------------------------------------------------------
// mmc_matrix
// Rotation product, scaling, translation and saturation of the model matrix.
// Six register stages, one entity per cycle while enabled.
// ----------------------------------------------------------------------------
module mmc_matrix #(
  parameter int F = mmc_pkg::FractionBits
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [2:0][F+1:0]        sin_i,
  input  logic [2:0][F+1:0]        cos_i,
  input  logic [2:0][15:0]         scale_i,
  input  logic [2:0][31:0]         pos_i,
  output mmc_pkg::mat_t            mat_o
);

  localparam int MW = F + 3;
  localparam int AW = 2 * MW + 2;
  localparam int SW = MW + 16;
  localparam int XW = SW - (F - 8);
  localparam int PW = MW + 32;
  localparam int QW = PW + 2;
  localparam int VW = QW - F;
  localparam int TW = VW + 16;

  logic signed [MW-1:0] one;
  logic signed [MW-1:0] rx [3][3];
  logic signed [MW-1:0] ry [3][3];
  logic signed [MW-1:0] pm_q [3][3];
  logic signed [MW-1:0] r_q [3][3];
  logic signed [MW-1:0] pm_d [3][3];
  logic signed [XW-1:0] a_q [3][3];
  logic signed [XW-1:0] a4_q [3][3];
  logic signed [XW-1:0] a5_q [3][3];
  logic signed [PW-1:0] rp_q [3][3];
  logic signed [VW-1:0] v_q [3];
  logic signed [TW-7:0] t_q [3];
  logic [2:0][15:0]     s1_q, s2_q, s3_q, s4_q;
  logic [2:0][31:0]     p1_q, p2_q;
  mmc_pkg::mat_t        mat_q;

  // Build the rotations about x and y
  always_comb begin
    one = MW'(1) <<< F;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rx[i][j] = '0;
        ry[i][j] = '0;
      end
    end
    rx[0][0] = one;
    rx[1][1] = MW'($signed(cos_i[0]));
    rx[1][2] = -MW'($signed(sin_i[0]));
    rx[2][1] = MW'($signed(sin_i[0]));
    rx[2][2] = MW'($signed(cos_i[0]));
    ry[1][1] = one;
    ry[0][0] = MW'($signed(cos_i[1]));
    ry[0][2] = MW'($signed(sin_i[1]));
    ry[2][0] = -MW'($signed(sin_i[1]));
    ry[2][2] = MW'($signed(cos_i[1]));
  end

  // Multiply Rx*Ry, rounding each entry
  always_comb begin
    logic signed [AW-1:0] acc;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = AW'(1) <<< (F - 1);
        for (int k = 0; k < 3; k++) begin
          acc = acc + AW'(rx[i][k]) * AW'(ry[k][j]);
        end
        pm_d[i][j] = MW'(acc >>> F);
      end
    end
  end

  // Hold the Rz angle pieces one stage to line up with Rx*Ry
  logic [2:0][F+1:0] sin1_q, cos1_q;
  logic signed [MW-1:0] rz1 [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rz1[i][j] = '0;
      end
    end
    rz1[2][2] = one;
    rz1[0][0] = MW'($signed(cos1_q[2]));
    rz1[0][1] = -MW'($signed(sin1_q[2]));
    rz1[1][0] = MW'($signed(sin1_q[2]));
    rz1[1][1] = MW'($signed(cos1_q[2]));
  end

  logic signed [MW-1:0] rr_d [3][3];
  always_comb begin
    logic signed [AW-1:0] acc3;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc3 = AW'(1) <<< (F - 1);
        for (int k = 0; k < 3; k++) begin
          acc3 = acc3 + AW'(pm_q[i][k]) * AW'(rz1[k][j]);
        end
        rr_d[i][j] = MW'(acc3 >>> F);
      end
    end
  end

  // Scale the rotation rows, form rotation times position and scale it
  always_ff @(posedge clk_i) begin
    logic signed [SW-1:0] sp;
    logic signed [QW-1:0] vs;
    logic signed [TW-1:0] ts;
    if (en_i) begin
      pm_q   <= pm_d;
      sin1_q <= sin_i;
      cos1_q <= cos_i;
      s1_q   <= scale_i;
      p1_q   <= pos_i;
      r_q    <= rr_d;
      s2_q   <= s1_q;
      p2_q   <= p1_q;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          sp         = SW'($signed(s2_q[i])) * SW'(r_q[i][k]);
          a_q[i][k]  <= XW'((sp + ((SW'(1) <<< (F - 8)) >>> 1)) >>> (F - 8));
          rp_q[i][k] <= PW'(r_q[i][k]) * PW'($signed(p2_q[k]));
        end
      end
      s3_q <= s2_q;
      a4_q <= a_q;
      for (int i = 0; i < 3; i++) begin
        vs     = QW'(rp_q[i][0]) + QW'(rp_q[i][1]) + QW'(rp_q[i][2]) + (QW'(1) <<< (F - 1));
        v_q[i] <= VW'(vs >>> F);
      end
      s4_q <= s3_q;
      a5_q <= a4_q;
      for (int i = 0; i < 3; i++) begin
        ts     = TW'($signed(s4_q[i])) * TW'(v_q[i]) + TW'(128);
        t_q[i] <= (TW - 6)'(ts >>> 8);
      end
      // Saturate and place the columns; rotate -90 deg about x
      for (int i = 0; i < 3; i++) begin
        mat_q.col[0][i] <= mmc_pkg::sat32(64'(a5_q[i][0]));
        mat_q.col[1][i] <= mmc_pkg::sat32(-64'(a5_q[i][2]));
        mat_q.col[2][i] <= mmc_pkg::sat32(64'(a5_q[i][1]));
        mat_q.col[3][i] <= mmc_pkg::sat32(64'(t_q[i]));
      end
    end
  end

  assign mat_o = mat_q;

endmodule

>>> sv/mmc_serial.sv
// ----------------------------------------------------------------------------
// mmc_serial
// Holds one finished matrix and sends it as four column transactions.
// ----------------------------------------------------------------------------
module mmc_serial (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mmc_pkg::mat_t    mat_i,
  output logic             load_ok_o,
  mmc_out_if.source        out_o
);

  logic          busy_q, busy_d;
  logic [1:0]    cnt_q, cnt_d;
  mmc_pkg::mat_t mat_q;
  logic          take;

  assign take      = out_o.valid && out_o.ready;
  assign load_ok_o = !busy_q || (take && (cnt_q == 2'd3));

  // Count columns, free up after the last one
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (take) begin
      cnt_d = 2'(cnt_q + 2'd1);
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
      end
    end
    if (load_i) begin
      busy_d = 1'b1;
      cnt_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mat_q <= mat_i;
    end
  end

  // Drive the current column
  assign out_o.valid        = busy_q;
  assign out_o.column_index = cnt_q;
  assign out_o.elem_row0    = mat_q.col[cnt_q][0];
  assign out_o.elem_row1    = mat_q.col[cnt_q][1];
  assign out_o.elem_row2    = mat_q.col[cnt_q][2];
  assign out_o.elem_row3    = (cnt_q == 2'd3) ? mmc_pkg::OneQ16 : 32'h0;
  assign out_o.last_column  = (cnt_q == 2'd3);

endmodule

>>> sv/model_matrix_compose.sv
// ----------------------------------------------------------------------------
// model_matrix_compose
// Builds an entity's 4x4 model matrix from scale, Euler angles and position.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  takes one entity per transaction (Q8.8 scale, angles in 1/64 deg,
//         Q16.16 position).
//   out_o gives four column transactions per entity, column 0 first; the
//         fourth carries last_column and the Q16.16 value 1.0 in row 3.
// Throughput: one entity per four column transactions, set by the single
//   column port; the 15-stage pipeline itself takes one entity per cycle
//   while not stalled and fills while the output register still sends
//   the previous matrix.
// Stall: when out_o is not ready the whole pipeline holds as soon as a
//   finished matrix waits at its end; in_i.ready drops with it. Nothing is
//   lost or repeated.
// Reset: clears all valid bits and the column counter; no transaction is in
//   flight afterwards.
// ----------------------------------------------------------------------------
module model_matrix_compose #(
  parameter int SINE_TABLE_DEPTH = mmc_pkg::SineTableDepth,
  parameter int FRACTION_BITS    = mmc_pkg::FractionBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mmc_in_if.sink    in_i,
  mmc_out_if.source out_o
);

  localparam int F    = FRACTION_BITS;
  localparam int DLY  = mmc_pkg::SincosLatency;
  localparam int LAST = DLY + mmc_pkg::MatrixLatency;

  logic               en;
  logic               load_ok;
  logic [LAST:0]      v_q;
  logic [2:0][15:0]   s0_q;
  logic [2:0][15:0]   ang0_q;
  logic [2:0][31:0]   p0_q;
  logic [2:0][15:0]   s_dly_q [DLY];
  logic [2:0][31:0]   p_dly_q [DLY];
  logic [2:0][F+1:0]  sin_w, cos_w;
  mmc_pkg::mat_t      mat_w;

  // Advance whenever the end of the pipeline is empty or can unload
  assign en       = !v_q[LAST] || load_ok;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAST-1:0], in_i.valid};
    end
  end

  // Register the transaction and delay scale and position alongside the angles
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q   <= {in_i.scale_z, in_i.scale_y, in_i.scale_x};
      ang0_q <= {in_i.angle_z, in_i.angle_y, in_i.angle_x};
      p0_q   <= {in_i.pos_z, in_i.pos_y, in_i.pos_x};
      s_dly_q[0] <= s0_q;
      p_dly_q[0] <= p0_q;
      for (int i = 1; i < DLY; i++) begin
        s_dly_q[i] <= s_dly_q[i-1];
        p_dly_q[i] <= p_dly_q[i-1];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_ang
    mmc_sincos #(.D(SINE_TABLE_DEPTH), .F(F), .COS(1'b0)) u_sin (
      .clk_i   (clk_i),
      .en_i    (en),
      .angle_i ($signed(ang0_q[g])),
      .value_o (sin_w[g])
    );
    mmc_sincos #(.D(SINE_TABLE_DEPTH), .F(F), .COS(1'b1)) u_cos (
      .clk_i   (clk_i),
      .en_i    (en),
      .angle_i ($signed(ang0_q[g])),
      .value_o (cos_w[g])
    );
  end

  mmc_matrix #(.F(F)) u_matrix (
    .clk_i   (clk_i),
    .en_i    (en),
    .sin_i   (sin_w),
    .cos_i   (cos_w),
    .scale_i (s_dly_q[DLY-1]),
    .pos_i   (p_dly_q[DLY-1]),
    .mat_o   (mat_w)
  );

  mmc_serial u_serial (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (v_q[LAST] && load_ok),
    .mat_i     (mat_w),
    .load_ok_o (load_ok),
    .out_o     (out_o)
  );

endmodule
